/* rtl/core/sfc_pkg.sv */
package sfc_pkg;

  // Register indexes on the configuration channel
  localparam logic [2:0] REG_ROT_ROW_X   = 3'd0;
  localparam logic [2:0] REG_ROT_ROW_Y   = 3'd1;
  localparam logic [2:0] REG_ROT_ROW_Z   = 3'd2;
  localparam logic [2:0] REG_SHIFT_XY    = 3'd3;
  localparam logic [2:0] REG_SHIFT_Z     = 3'd4;
  localparam logic [2:0] REG_PLANE_TERMS = 3'd5;
  localparam logic [2:0] REG_FAR_DIST    = 3'd6;

  // Reset values: identity rotation, no translation, 45 degree planes, far 100.0
  localparam logic [47:0] RST_ROT_ROW_X   = 48'd16384;
  localparam logic [47:0] RST_ROT_ROW_Y   = 48'd1073741824;
  localparam logic [47:0] RST_ROT_ROW_Z   = 48'd70368744177664;
  localparam logic [63:0] RST_SHIFT_XY    = 64'd0;
  localparam logic [31:0] RST_SHIFT_Z     = 32'd0;
  localparam logic [63:0] RST_PLANE_TERMS = 64'd3260937363148320065;
  localparam logic [30:0] RST_FAR_DIST    = 31'd6553600;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned RAD_W   = 31;
  localparam int unsigned VIEW_W  = 37;

  typedef enum logic [2:0] {
    REJ_NONE   = 3'd0,
    REJ_FAR    = 3'd1,
    REJ_LEFT   = 3'd2,
    REJ_RIGHT  = 3'd3,
    REJ_BOTTOM = 3'd4,
    REJ_TOP    = 3'd5
  } sfc_reject_t;

  typedef struct packed {
    logic [47:0] rot_row_x;
    logic [47:0] rot_row_y;
    logic [47:0] rot_row_z;
    logic [63:0] shift_xy;
    logic [31:0] shift_z;
    logic [63:0] plane_terms;
    logic [30:0] far_dist;
  } sfc_cfg_t;

  // Sphere center in view space, signed Q21.16 with full integer range
  typedef struct packed {
    logic signed [VIEW_W-1:0] vx;
    logic signed [VIEW_W-1:0] vy;
    logic signed [VIEW_W-1:0] vz;
    logic [RAD_W-1:0]         radius;
  } sfc_view_t;

endpackage

/* rtl/core/sfc_if.sv */
interface sfc_in_if;
  import sfc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic [RAD_W-1:0]          sphere_radius;
  modport source (output valid, center_x, center_y, center_z, sphere_radius, input ready);
  modport sink (input valid, center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface sfc_out_if;
  logic       valid;
  logic       ready;
  logic       visible;
  logic [2:0] reject_plane;
  modport source (output valid, visible, reject_plane, input ready);
  modport sink (input valid, visible, reject_plane, output ready);
endinterface

interface sfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/sphere_frustum_cull.sv */
// A sphere passes through stage registers A, B, C and D in that order, and
// its result is held in stage D until the result channel takes it.
// Throughput: one sphere per cycle while results are taken; four register
// stages (matrix products, row sums, plane products, plane compares) hold one item each.
// Ready back-propagates stage by stage, so bubbles are filled during a stall.
// Reset (rst, synchronous) empties the pipeline and loads the default view.
module sphere_frustum_cull (
  input  logic      clk,
  input  logic      rst,
  sfc_in_if.sink    sphere,
  sfc_out_if.source result,
  sfc_cfg_if.sink   cfg
);
  import sfc_pkg::*;

  sfc_cfg_t  regs;
  sfc_view_t view;
  logic      view_valid;
  logic      view_ready;

  sfc_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  sfc_xform u_xform (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .sphere     (sphere),
    .view_valid (view_valid),
    .view_ready (view_ready),
    .view       (view)
  );

  sfc_test u_test (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .view_valid (view_valid),
    .view_ready (view_ready),
    .view       (view),
    .result     (result)
  );

endmodule

/* rtl/core/sfc_regs.sv */
module sfc_regs (
  input  logic             clk,
  input  logic             rst,
  sfc_cfg_if.sink          cfg,
  output sfc_pkg::sfc_cfg_t regs
);
  import sfc_pkg::*;

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Load the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rot_row_x   <= RST_ROT_ROW_X;
      regs.rot_row_y   <= RST_ROT_ROW_Y;
      regs.rot_row_z   <= RST_ROT_ROW_Z;
      regs.shift_xy    <= RST_SHIFT_XY;
      regs.shift_z     <= RST_SHIFT_Z;
      regs.plane_terms <= RST_PLANE_TERMS;
      regs.far_dist    <= RST_FAR_DIST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROT_ROW_X:   regs.rot_row_x   <= cfg.data[47:0];
        REG_ROT_ROW_Y:   regs.rot_row_y   <= cfg.data[47:0];
        REG_ROT_ROW_Z:   regs.rot_row_z   <= cfg.data[47:0];
        REG_SHIFT_XY:    regs.shift_xy    <= cfg.data;
        REG_SHIFT_Z:     regs.shift_z     <= cfg.data[31:0];
        REG_PLANE_TERMS: regs.plane_terms <= cfg.data;
        REG_FAR_DIST:    regs.far_dist    <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/sfc_xform.sv */
module sfc_xform (
  input  logic              clk,
  input  logic              rst,
  input  sfc_pkg::sfc_cfg_t regs,
  sfc_in_if.sink            sphere,
  output logic              view_valid,
  input  logic              view_ready,
  output sfc_pkg::sfc_view_t view
);
  import sfc_pkg::*;

  // Stage A: nine matrix products, Q.30
  logic                a_v;
  logic signed [47:0]  a_p [9];
  logic [RAD_W-1:0]    a_r;
  logic                a_rdy;

  // Stage B: view coordinates
  logic                b_v;
  logic                b_rdy;

  logic signed [15:0]  rt [9];
  logic signed [50:0]  acc [3];
  logic signed [31:0]  tr [3];

  assign b_rdy        = !b_v || view_ready;
  assign a_rdy        = !a_v || b_rdy;
  assign sphere.ready = a_rdy;
  assign view_valid   = b_v;

  // Unpack the rotation terms, row major
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rt[k]     = $signed(regs.rot_row_x[16*k +: 16]);
      rt[3 + k] = $signed(regs.rot_row_y[16*k +: 16]);
      rt[6 + k] = $signed(regs.rot_row_z[16*k +: 16]);
    end
  end

  assign tr[0] = $signed(regs.shift_xy[31:0]);
  assign tr[1] = $signed(regs.shift_xy[63:32]);
  assign tr[2] = $signed(regs.shift_z);

  // Advance stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_rdy) begin
      a_v <= sphere.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && sphere.valid) begin
      for (int k = 0; k < 3; k++) begin
        a_p[3*k]     <= rt[3*k]     * sphere.center_x;
        a_p[3*k + 1] <= rt[3*k + 1] * sphere.center_y;
        a_p[3*k + 2] <= rt[3*k + 2] * sphere.center_z;
      end
      a_r <= sphere.sphere_radius;
    end
  end

  // Sum each row with the scaled translation
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = 51'(a_p[3*k]) + 51'(a_p[3*k + 1]) + 51'(a_p[3*k + 2])
             + 51'($signed({tr[k], 14'd0}));
    end
  end

  // Advance stage B; dropping 14 low bits rounds toward minus infinity
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_rdy) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_v) begin
      view.vx     <= acc[0][50:14];
      view.vy     <= acc[1][50:14];
      view.vz     <= acc[2][50:14];
      view.radius <= a_r;
    end
  end

endmodule

/* rtl/core/sfc_test.sv */
module sfc_test (
  input  logic               clk,
  input  logic               rst,
  input  sfc_pkg::sfc_cfg_t  regs,
  input  logic               view_valid,
  output logic               view_ready,
  input  sfc_pkg::sfc_view_t view,
  sfc_out_if.source          result
);
  import sfc_pkg::*;

  // Stage C: plane products and the far test
  logic               c_v;
  logic               c_rdy;
  logic               c_far;
  logic signed [52:0] c_xc;
  logic signed [52:0] c_zs;
  logic signed [52:0] c_yc;
  logic signed [52:0] c_zv;
  logic signed [45:0] c_lim;

  // Stage D: result register
  logic               d_v;
  logic               d_rdy;
  logic               d_vis;
  sfc_reject_t        d_plane;

  logic signed [15:0] ch, sh, cv, sv;
  logic [31:0]        far_sum;
  logic signed [37:0] far_lim;
  logic signed [53:0] s_left, s_right, s_bottom, s_top;
  sfc_reject_t        plane_next;

  assign d_rdy      = !d_v || result.ready;
  assign c_rdy      = !c_v || d_rdy;
  assign view_ready = c_rdy;

  assign ch = $signed(regs.plane_terms[15:0]);
  assign sh = $signed(regs.plane_terms[31:16]);
  assign cv = $signed(regs.plane_terms[47:32]);
  assign sv = $signed(regs.plane_terms[63:48]);

  assign far_sum = {1'b0, regs.far_dist} + {1'b0, view.radius};
  assign far_lim = -$signed({6'd0, far_sum});

  // Advance stage C
  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (c_rdy) begin
      c_v <= view_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy && view_valid) begin
      c_xc  <= view.vx * ch;
      c_zs  <= view.vz * sh;
      c_yc  <= view.vy * cv;
      c_zv  <= view.vz * sv;
      c_far <= $signed({view.vz[VIEW_W-1], view.vz}) < far_lim;
      c_lim <= -$signed({1'b0, view.radius, 14'd0});
    end
  end

  // Pick the first plane that rejects
  assign s_left   = 54'(c_xc) - 54'(c_zs);
  assign s_right  = -54'(c_xc) - 54'(c_zs);
  assign s_bottom = 54'(c_yc) - 54'(c_zv);
  assign s_top    = -54'(c_yc) - 54'(c_zv);

  always_comb begin
    priority if (c_far) begin
      plane_next = REJ_FAR;
    end else if (s_left < 54'(c_lim)) begin
      plane_next = REJ_LEFT;
    end else if (s_right < 54'(c_lim)) begin
      plane_next = REJ_RIGHT;
    end else if (s_bottom < 54'(c_lim)) begin
      plane_next = REJ_BOTTOM;
    end else if (s_top < 54'(c_lim)) begin
      plane_next = REJ_TOP;
    end else begin
      plane_next = REJ_NONE;
    end
  end

  // Advance stage D; hold while the result is not taken
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (d_rdy) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy && c_v) begin
      d_plane <= plane_next;
      d_vis   <= (plane_next == REJ_NONE);
    end
  end

  assign result.valid        = d_v;
  assign result.visible      = d_vis;
  assign result.reject_plane = d_plane;

  // A stalled result stays put
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    d_v && !result.ready |=> d_v && $stable(d_plane) && $stable(d_vis))
    else $error("result changed while stalled");

  // An item leaving stage C always lands in stage D
  a_c_to_d: assert property (@(posedge clk) disable iff (rst)
    c_v && c_rdy |=> d_v)
    else $error("item lost between stages C and D");

  // A blocked stage C keeps its item
  a_hold_c: assert property (@(posedge clk) disable iff (rst)
    c_v && !c_rdy |=> c_v && $stable(c_far) && $stable(c_lim))
    else $error("stage C changed while blocked");

endmodule
